FILE: rtl/sbbf_pkg.sv
// shared types, constants and rom tables of the single s-box blowfish cipher
package sbbf_pkg;

    localparam int ROUNDS            = 16;
    localparam int NKEYS             = ROUNDS + 2;
    localparam int SBOX_SIZE         = 256;
    localparam int MAX_KEY_BYTES_DEF = 56;
    localparam int P_BLOCKS          = NKEYS / 2;
    localparam int LAST_BLK          = P_BLOCKS + SBOX_SIZE / 2 - 1;
    localparam int KEY_BYTE_STEPS    = NKEYS * 4;

    // input item kinds
    localparam logic [1:0] KIND_KEY   = 2'd0;
    localparam logic [1:0] KIND_SCHED = 2'd1;
    localparam logic [1:0] KIND_ENC   = 2'd2;
    localparam logic [1:0] KIND_DEC   = 2'd3;

    // result kinds
    localparam logic [1:0] RES_SCHED  = 2'd0;
    localparam logic [1:0] RES_CIPHER = 2'd1;
    localparam logic [1:0] RES_PLAIN  = 2'd2;

    typedef enum logic [3:0] {
        PH_NONE,
        PH_APPEND,
        PH_LOAD,
        PH_ROMS,
        PH_KEYX,
        PH_RA,
        PH_RB,
        PH_RC,
        PH_RD,
        PH_RE,
        PH_FINAL,
        PH_WRS1,
        PH_OUT
    } phase_t;

    typedef struct packed {
        phase_t     phase;
        logic       key_issue;
        logic       key_cap;
        logic [7:0] idx;
        logic [4:0] key_idx;
        logic       dir;
        logic       p_store;
        logic       s_store;
        logic [1:0] res_kind;
    } cmd_t;

    typedef struct packed {
        logic key_empty;
        logic out_free;
    } status_t;

    localparam logic [31:0] ROM_P [NKEYS] = '{
        32'h243F6A88, 32'h85A308D3, 32'h13198A2E, 32'h03707344,
        32'hA4093822, 32'h299F31D0, 32'h082EFA98, 32'hEC4E6C89,
        32'h452821E6, 32'h38D01377, 32'hBE5466CF, 32'h34E90C6C,
        32'hC0AC29B7, 32'hC97C50DD, 32'h3F84D5B5, 32'hB5470917,
        32'h9216D5D9, 32'h8979FB1B
    };

    localparam logic [31:0] ROM_S [SBOX_SIZE] = '{
        32'hD1310BA6, 32'h98DFB5AC, 32'h2FFD72DB, 32'hD01ADFB7,
        32'hB8E1AFED, 32'h6A267E96, 32'hBA7C9045, 32'hF12C7F99,
        32'h24A19947, 32'hB3916CF7, 32'h0801F2E2, 32'h858EFC16,
        32'h636920D8, 32'h71574E69, 32'hA458FEA3, 32'hF4933D7E,
        32'h0D95748F, 32'h728EB658, 32'h718BCD58, 32'h82154AEE,
        32'h7B54A41D, 32'hC25A59B5, 32'h9C30D539, 32'h2AF26013,
        32'hC5D1B023, 32'h286085F0, 32'hCA417918, 32'hB8DB38EF,
        32'h8E79DCB0, 32'h603A180E, 32'h6C9E0E8B, 32'hB01E8A3E,
        32'hD71577C1, 32'hBD314B27, 32'h78AF2FDA, 32'h55605C60,
        32'hE65525F3, 32'hAA55AB94, 32'h57489862, 32'h63E81440,
        32'h55CA396A, 32'h2AAB10B6, 32'hB4CC5C34, 32'h1141E8CE,
        32'hA15486AF, 32'h7C72E993, 32'hB3EE1411, 32'h636FBC2A,
        32'h2BA9C55D, 32'h741831F6, 32'hCE5C3E16, 32'h9B87931E,
        32'hAFD6BA33, 32'h6C24CF5C, 32'h7A325381, 32'h28958677,
        32'h3B8F4898, 32'h6B4BB9AF, 32'hC4BFE81B, 32'h66282193,
        32'h61D809CC, 32'hFB21A991, 32'h487CAC60, 32'h5DEC8032,
        32'hEF845D5D, 32'hE98575B1, 32'hDC262302, 32'hEB651B88,
        32'h23893E81, 32'hD396ACC5, 32'h0F6D6FF3, 32'h83F44239,
        32'h2E0B4482, 32'hA4842004, 32'h69C8F04A, 32'h9E1F9B5E,
        32'h21C66842, 32'hF6E96C9A, 32'h670C9C61, 32'hABD388F0,
        32'h6A51A0D2, 32'hD8542F68, 32'h960FA728, 32'hAB5133A3,
        32'h6EEF0B6C, 32'h137A3BE4, 32'hBA3BF050, 32'h7EFB2A98,
        32'hA1F1651D, 32'h39AF0176, 32'h66CA593E, 32'h82430E88,
        32'h8CEE8619, 32'h456F9FB4, 32'h7D84A5C3, 32'h3B8B5EBE,
        32'hE06F75D8, 32'h85C12073, 32'h401A449F, 32'h56C16AA6,
        32'h4ED3AA62, 32'h363F7706, 32'h1BFEDF72, 32'h429B023D,
        32'h37D0D724, 32'hD00A1248, 32'hDB0FEAD3, 32'h49F1C09B,
        32'h075372C9, 32'h80991B7B, 32'h25D479D8, 32'hF6E8DEF7,
        32'hE3FE501A, 32'hB6794C3B, 32'h976CE0BD, 32'h04C006BA,
        32'hC1A94FB6, 32'h409F60C4, 32'h5E5C9EC2, 32'h196A2463,
        32'h68FB6FAF, 32'h3E6C53B5, 32'h1339B2EB, 32'h3B52EC6F,
        32'h6DFC511F, 32'h9B30952C, 32'hCC814544, 32'hAF5EBD09,
        32'hBEE3D004, 32'hDE334AFD, 32'h660F2807, 32'h192E4BB3,
        32'hC0CBA857, 32'h45C8740F, 32'hD20B5F39, 32'hB9D3FBDB,
        32'h5579C0BD, 32'h1A60320A, 32'hD6A100C6, 32'h402C7279,
        32'h679F25FE, 32'hFB1FA3CC, 32'h8EA5E9F8, 32'hDB3222F8,
        32'h3C7516DF, 32'hFD616B15, 32'h2F501EC8, 32'hAD0552AB,
        32'h323DB5FA, 32'hFD238760, 32'h53317B48, 32'h3E00DF82,
        32'h9E5C57BB, 32'hCA6F8CA0, 32'h1A87562E, 32'hDF1769DB,
        32'hD542A8F6, 32'h287EFFC3, 32'hAC6732C6, 32'h8C4F5573,
        32'h695B27B0, 32'hBBCA58C8, 32'hE1FFA35D, 32'hB8F011A0,
        32'h10FA3D98, 32'hFD2183B8, 32'h4AFCB56C, 32'h2DD1D35B,
        32'h9A53E479, 32'hB6F84565, 32'hD28E49BC, 32'h4BFB9790,
        32'hE1DDF2DA, 32'hA4CB7E33, 32'h62FB1341, 32'hCEE4C6E8,
        32'hEF20CADA, 32'h36774C01, 32'hD07E9EFE, 32'h2BF11FB4,
        32'h95DBDA4D, 32'hAE909198, 32'hEAAD8E71, 32'h6B93D5A0,
        32'hD08ED1D0, 32'hAFC725E0, 32'h8E3C5B2F, 32'h8E7594B7,
        32'h8FF6E2FB, 32'hF2122B64, 32'h8888B812, 32'h900DF01C,
        32'h4FAD5EA0, 32'h688FC31C, 32'hD1CFF191, 32'hB3A8C1AD,
        32'h2F2F2218, 32'hBE0E1777, 32'hEA752DFE, 32'h8B021FA1,
        32'hE5A0CC0F, 32'hB56F74E8, 32'h18ACF3D6, 32'hCE89E299,
        32'hB4A84FE0, 32'hFD13E0B7, 32'h7CC43B81, 32'hD2ADA8D9,
        32'h165FA266, 32'h80957705, 32'h93CC7314, 32'h211A1477,
        32'hE6AD2065, 32'h77B5FA86, 32'hC75442F5, 32'hFB9D35CF,
        32'hEBCDAF0C, 32'h7B3E89A0, 32'hD6411BD3, 32'hAE1E7E49,
        32'h00250E2D, 32'h2071B35E, 32'h226800BB, 32'h57B8E0AF,
        32'h2464369B, 32'hF009B91E, 32'h5563911D, 32'h59DFA6AA,
        32'h78C14389, 32'hD95A537F, 32'h207D5BA2, 32'h02E5B9C5,
        32'h83260376, 32'h6295CFA9, 32'h11C81968, 32'h4E734A41,
        32'hB3472DCA, 32'h7B14A94A, 32'h1B510052, 32'h9A532915,
        32'hD60F573F, 32'hBC9BC6E4, 32'h2B60A476, 32'h81E67400,
        32'h08BA6FB5, 32'h571BE91F, 32'hF296EC6B, 32'h2A0DD915,
        32'hB6636521, 32'hE7B9F9B6, 32'hFF34052E, 32'hC5855664,
        32'h53B02D5D, 32'hA99F8FA1, 32'h08BA4799, 32'h6E85076A
    };

endpackage

FILE: rtl/single_sbox_blowfish_cipher.sv
// top level of the single s-box blowfish cipher
// blowfish reduced to one 256-entry s-box. key bytes are appended one per
// transfer (no result, ignored once MAX_KEY_BYTES are held); a schedule
// transfer reloads the rom tables (one s-box entry per cycle), xors the
// cycled key into the round keys when a key is present (one key byte per
// cycle from the key store), then runs 137 chained encryptions, plus a
// second write step per s-box pair, and one output load. in encrypt and
// decrypt each of the 16 rounds steps through the states RA to RE because
// the single read port of the s-box memory serves the four byte lookups one
// after another, then follow a whitening step and one output load. one item
// is worked on at a time; the result register lets a finished result wait
// while the next item is taken. blocks must follow a schedule.
module single_sbox_blowfish_cipher #(
    parameter int MAX_KEY_BYTES = sbbf_pkg::MAX_KEY_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [7:0]  s_key_byte,
    input  logic [31:0] s_block_hi,
    input  logic [31:0] s_block_lo,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_result_kind,
    output logic [31:0] m_result_hi,
    output logic [31:0] m_result_lo
);
    import sbbf_pkg::*;

    // command and status between controller and datapath
    cmd_t    cmd;
    status_t status;

    sbbf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_kind  (s_kind),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    sbbf_datapath #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .s_key_byte    (s_key_byte),
        .s_block_hi    (s_block_hi),
        .s_block_lo    (s_block_lo),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_result_kind (m_result_kind),
        .m_result_hi   (m_result_hi),
        .m_result_lo   (m_result_lo)
    );

endmodule

FILE: rtl/sbbf_ctrl.sv
// controller state machine of the single s-box blowfish cipher
module sbbf_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic [1:0]       s_kind,
    output logic             s_ready,
    input  sbbf_pkg::status_t status,
    output sbbf_pkg::cmd_t    cmd
);
    import sbbf_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_LOADS = 10'b0000000010,
        ST_KEYX  = 10'b0000000100,
        ST_RA    = 10'b0000001000,
        ST_RB    = 10'b0000010000,
        ST_RC    = 10'b0000100000,
        ST_RD    = 10'b0001000000,
        ST_RE    = 10'b0010000000,
        ST_FINAL = 10'b0100000000,
        ST_OUT   = 10'b1000000000
    } state_t;

    // second s-box write of a pair reuses the idle code space via a flag
    state_t     state_reg, state_next;
    logic       wrs1_reg, wrs1_next;
    logic [7:0] cnt_reg, cnt_next;
    logic [3:0] round_reg, round_next;
    logic [7:0] blk_reg, blk_next;
    logic       dir_reg, dir_next;
    logic       sched_reg, sched_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            wrs1_reg  <= 1'b0;
            cnt_reg   <= '0;
            round_reg <= '0;
            blk_reg   <= '0;
            dir_reg   <= 1'b0;
            sched_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            wrs1_reg  <= wrs1_next;
            cnt_reg   <= cnt_next;
            round_reg <= round_next;
            blk_reg   <= blk_next;
            dir_reg   <= dir_next;
            sched_reg <= sched_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        wrs1_next  = 1'b0;
        cnt_next   = cnt_reg;
        round_next = round_reg;
        blk_next   = blk_reg;
        dir_next   = dir_reg;
        sched_next = sched_reg;
        s_ready    = 1'b0;

        cmd           = '0;
        cmd.phase     = PH_NONE;
        cmd.dir       = dir_reg;
        cmd.key_idx   = dir_reg ? (5'(NKEYS - 1) - {1'b0, round_reg}) : {1'b0, round_reg};
        cmd.res_kind  = sched_reg ? RES_SCHED : (dir_reg ? RES_PLAIN : RES_CIPHER);
        cmd.idx       = blk_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (wrs1_reg) begin
                    cmd.phase = PH_WRS1;
                    if (blk_reg == 8'(LAST_BLK)) begin
                        state_next = ST_OUT;
                    end else begin
                        blk_next   = blk_reg + 8'd1;
                        round_next = '0;
                        state_next = ST_RA;
                    end
                end else begin
                    s_ready = 1'b1;
                    if (s_valid) begin
                        unique case (s_kind)
                            KIND_KEY: begin
                                cmd.phase = PH_APPEND;
                            end
                            KIND_SCHED: begin
                                sched_next = 1'b1;
                                dir_next   = 1'b0;
                                cnt_next   = '0;
                                state_next = ST_LOADS;
                            end
                            default: begin
                                cmd.phase  = PH_LOAD;
                                sched_next = 1'b0;
                                dir_next   = (s_kind == KIND_DEC);
                                round_next = '0;
                                state_next = ST_RA;
                            end
                        endcase
                    end
                end
            end
            ST_LOADS: begin
                cmd.phase = PH_ROMS;
                cmd.idx   = cnt_reg;
                cnt_next  = cnt_reg + 8'd1;
                if (cnt_reg == 8'(SBOX_SIZE - 1)) begin
                    blk_next   = '0;
                    round_next = '0;
                    cnt_next   = '0;
                    state_next = status.key_empty ? ST_RA : ST_KEYX;
                end
            end
            ST_KEYX: begin
                cmd.phase     = PH_KEYX;
                cmd.key_issue = (cnt_reg < 8'(KEY_BYTE_STEPS));
                cmd.key_cap   = (cnt_reg != 8'd0);
                cmd.idx       = cnt_reg - 8'd1;
                cnt_next      = cnt_reg + 8'd1;
                if (cnt_reg == 8'(KEY_BYTE_STEPS)) begin
                    state_next = ST_RA;
                end
            end
            ST_RA: begin
                cmd.phase  = PH_RA;
                state_next = ST_RB;
            end
            ST_RB: begin
                cmd.phase  = PH_RB;
                state_next = ST_RC;
            end
            ST_RC: begin
                cmd.phase  = PH_RC;
                state_next = ST_RD;
            end
            ST_RD: begin
                cmd.phase  = PH_RD;
                state_next = ST_RE;
            end
            ST_RE: begin
                cmd.phase = PH_RE;
                if (round_reg == 4'(ROUNDS - 1)) begin
                    state_next = ST_FINAL;
                end else begin
                    round_next = round_reg + 4'd1;
                    state_next = ST_RA;
                end
            end
            ST_FINAL: begin
                cmd.phase   = PH_FINAL;
                cmd.p_store = sched_reg && (blk_reg < 8'(P_BLOCKS));
                cmd.s_store = sched_reg && (blk_reg >= 8'(P_BLOCKS));
                if (!sched_reg) begin
                    state_next = ST_OUT;
                end else if (blk_reg < 8'(P_BLOCKS)) begin
                    blk_next   = blk_reg + 8'd1;
                    round_next = '0;
                    state_next = ST_RA;
                end else begin
                    wrs1_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.phase  = PH_OUT;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/sbbf_datapath.sv
// datapath of the single s-box blowfish cipher: tables, key store, block registers
module sbbf_datapath #(
    parameter int MAX_KEY_BYTES = sbbf_pkg::MAX_KEY_BYTES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  sbbf_pkg::cmd_t    cmd,
    output sbbf_pkg::status_t status,
    input  logic [7:0]        s_key_byte,
    input  logic [31:0]       s_block_hi,
    input  logic [31:0]       s_block_lo,
    input  logic              m_ready,
    output logic              m_valid,
    output logic [1:0]        m_result_kind,
    output logic [31:0]       m_result_hi,
    output logic [31:0]       m_result_lo
);
    import sbbf_pkg::*;

    localparam int KA_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

    logic [31:0] p_reg [NKEYS];
    logic [31:0] sbox_mem [SBOX_SIZE];
    logic [31:0] sb_rd_reg;
    logic [7:0]  key_mem [MAX_KEY_BYTES];
    logic [7:0]  key_rd_reg;
    logic [5:0]  key_count_reg;
    logic [5:0]  j_reg;
    logic [23:0] w_reg;
    logic [31:0] h_reg, l_reg, acc_reg;
    logic        m_valid_reg;
    logic [1:0]  m_kind_reg;
    logic [31:0] m_hi_reg, m_lo_reg;

    logic [31:0] pk, hx, fin_h, fin_l, f_val, sb_wdata, w_full;
    logic [7:0]  sb_raddr, sb_waddr;
    logic [6:0]  pair;
    logic        sb_we, key_we;
    logic [6:0]  j_inc;
    logic [5:0]  j_next;

    assign pk     = p_reg[cmd.key_idx];
    assign hx     = h_reg ^ pk;
    assign fin_h  = l_reg ^ (cmd.dir ? p_reg[0] : p_reg[NKEYS - 1]);
    assign fin_l  = h_reg ^ (cmd.dir ? p_reg[1] : p_reg[NKEYS - 2]);
    assign f_val  = acc_reg + sb_rd_reg;
    assign w_full = {w_reg, key_rd_reg};
    assign pair   = 7'(cmd.idx - 8'(P_BLOCKS));

    // cycled key pointer wraps at the current key length
    assign j_inc  = {1'b0, j_reg} + 7'd1;
    assign j_next = (j_inc >= {1'b0, key_count_reg}) ? 6'd0 : j_inc[5:0];

    assign key_we = (cmd.phase == PH_APPEND) && (key_count_reg < 6'(MAX_KEY_BYTES));

    always_comb begin
        unique case (cmd.phase)
            PH_RA:   sb_raddr = hx[31:24];
            PH_RB:   sb_raddr = h_reg[23:16];
            PH_RC:   sb_raddr = h_reg[15:8];
            default: sb_raddr = h_reg[7:0];
        endcase
    end

    always_comb begin
        sb_we    = 1'b0;
        sb_waddr = cmd.idx;
        sb_wdata = ROM_S[cmd.idx];
        unique case (cmd.phase)
            PH_ROMS: begin
                sb_we = 1'b1;
            end
            PH_FINAL: begin
                sb_we    = cmd.s_store;
                sb_waddr = {pair, 1'b0};
                sb_wdata = fin_h;
            end
            PH_WRS1: begin
                sb_we    = 1'b1;
                sb_waddr = {pair, 1'b1};
                sb_wdata = l_reg;
            end
            default: begin
                sb_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (sb_we) begin
            sbox_mem[sb_waddr] <= sb_wdata;
        end
        sb_rd_reg <= sbox_mem[sb_raddr];
    end

    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[key_count_reg[KA_W-1:0]] <= s_key_byte;
        end
        key_rd_reg <= key_mem[j_reg[KA_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_count_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (key_we) begin
                key_count_reg <= key_count_reg + 6'd1;
            end
            if (cmd.phase == PH_OUT) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.phase)
            PH_ROMS: begin
                for (int i = 0; i < NKEYS; i++) begin
                    p_reg[i] <= ROM_P[i];
                end
                h_reg <= '0;
                l_reg <= '0;
                j_reg <= '0;
            end
            PH_KEYX: begin
                if (cmd.key_issue) begin
                    j_reg <= j_next;
                end
                if (cmd.key_cap) begin
                    w_reg <= w_full[23:0];
                    if (cmd.idx[1:0] == 2'd3) begin
                        p_reg[cmd.idx[6:2]] <= p_reg[cmd.idx[6:2]] ^ w_full;
                    end
                end
            end
            PH_LOAD: begin
                h_reg <= s_block_hi;
                l_reg <= s_block_lo;
            end
            PH_RA: begin
                h_reg <= hx;
            end
            PH_RB: begin
                acc_reg <= sb_rd_reg;
            end
            PH_RC: begin
                acc_reg <= acc_reg + sb_rd_reg;
            end
            PH_RD: begin
                acc_reg <= acc_reg ^ sb_rd_reg;
            end
            PH_RE: begin
                h_reg <= l_reg ^ f_val;
                l_reg <= h_reg;
            end
            PH_FINAL: begin
                h_reg <= fin_h;
                l_reg <= fin_l;
                if (cmd.p_store) begin
                    p_reg[{cmd.idx[3:0], 1'b0}] <= fin_h;
                    p_reg[{cmd.idx[3:0], 1'b1}] <= fin_l;
                end
            end
            PH_OUT: begin
                m_kind_reg <= cmd.res_kind;
                m_hi_reg   <= (cmd.res_kind == RES_SCHED) ? 32'd0 : h_reg;
                m_lo_reg   <= (cmd.res_kind == RES_SCHED) ? 32'd0 : l_reg;
            end
            default: begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign status.key_empty = (key_count_reg == 6'd0);
    assign status.out_free  = !m_valid_reg || m_ready;

    assign m_valid       = m_valid_reg;
    assign m_result_kind = m_kind_reg;
    assign m_result_hi   = m_hi_reg;
    assign m_result_lo   = m_lo_reg;

endmodule

FILE: rtl/sbbf_checker.sv
// port-level checker of the single s-box blowfish cipher and its bind
module sbbf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [1:0]  s_kind,
    input logic [7:0]  s_key_byte,
    input logic [31:0] s_block_hi,
    input logic [31:0] s_block_lo,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_result_kind,
    input logic [31:0] m_result_hi,
    input logic [31:0] m_result_lo
);
    import sbbf_pkg::*;

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_result_hi) && $stable(m_result_lo)))
        else $error("stalled result changed");

    a_key_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_kind == KIND_KEY) |=> s_ready)
        else $error("key append blocked input");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_kind != KIND_KEY) |=> !s_ready)
        else $error("input taken while busy");

    a_kind_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_result_kind == RES_SCHED || m_result_kind == RES_CIPHER ||
                     m_result_kind == RES_PLAIN))
        else $error("illegal result kind");

endmodule

bind single_sbox_blowfish_cipher sbbf_checker u_chk (.*);

FILE: dv/single_sbox_blowfish_cipher_checker.sv
// transfer monitor, cipher predictor and result comparison for the blowfish block
`timescale 1ns / 100ps
module single_sbox_blowfish_cipher_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [7:0]  s_key_byte,
    input  logic [31:0] s_block_hi,
    input  logic [31:0] s_block_lo,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_result_kind,
    input  logic [31:0] m_result_hi,
    input  logic [31:0] m_result_lo,
    output int          errors,
    output int          pending
);
    import sbbf_pkg::*;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] hi;
        logic [31:0] lo;
    } outcome_t;

    logic [31:0] sbox_mem [SBOX_SIZE];
    logic [31:0] pkeys [NKEYS];
    logic [7:0]  key_bytes [MAX_KEY_BYTES_DEF];
    int          key_len;
    outcome_t    awaited [$];

    function automatic logic [31:0] round_f(input logic [31:0] x);
        return ((sbox_mem[x[31:24]] + sbox_mem[x[23:16]]) ^ sbox_mem[x[15:8]])
               + sbox_mem[x[7:0]];
    endfunction

    // 16 rounds, then undo the last swap and whiten with the outer keys
    function automatic void cipher_block(input logic inverse,
                                         inout logic [31:0] h, inout logic [31:0] l);
        logic [31:0] t;
        for (int r = 0; r < ROUNDS; r++) begin
            h ^= pkeys[inverse ? (NKEYS - 1 - r) : r];
            l ^= round_f(h);
            t = h; h = l; l = t;
        end
        t = h; h = l; l = t;
        if (inverse) begin
            l ^= pkeys[1];
            h ^= pkeys[0];
        end else begin
            l ^= pkeys[NKEYS - 2];
            h ^= pkeys[NKEYS - 1];
        end
    endfunction

    function automatic void expand_key();
        logic [31:0] h, l, w;
        int j;
        h = '0; l = '0; j = 0;
        for (int i = 0; i < SBOX_SIZE; i++) sbox_mem[i] = ROM_S[i];
        for (int i = 0; i < NKEYS; i++) pkeys[i] = ROM_P[i];
        if (key_len != 0) begin
            for (int i = 0; i < NKEYS; i++) begin
                w = '0;
                for (int k = 0; k < 4; k++) begin
                    w = {w[23:0], key_bytes[j]};
                    j++;
                    if (j >= key_len) j = 0;
                end
                pkeys[i] ^= w;
            end
        end
        for (int i = 0; i < NKEYS; i += 2) begin
            cipher_block(1'b0, h, l);
            pkeys[i] = h; pkeys[i + 1] = l;
        end
        for (int i = 0; i < SBOX_SIZE; i += 2) begin
            cipher_block(1'b0, h, l);
            sbox_mem[i] = h; sbox_mem[i + 1] = l;
        end
    endfunction

    assign pending = awaited.size();

    always @(posedge aclk) begin
        logic [31:0] h, l;
        outcome_t got, want;
        if (!aresetn) begin
            key_len = 0;
            errors  <= 0;
            awaited.delete();
        end else begin
            if (s_valid && s_ready) begin
                h = s_block_hi;
                l = s_block_lo;
                case (s_kind)
                    KIND_KEY: begin
                        if (key_len < MAX_KEY_BYTES_DEF) begin
                            key_bytes[key_len] = s_key_byte;
                            key_len = key_len + 1;
                        end
                    end
                    KIND_SCHED: begin
                        expand_key();
                        awaited.push_back('{RES_SCHED, 32'h0, 32'h0});
                    end
                    KIND_ENC: begin
                        cipher_block(1'b0, h, l);
                        awaited.push_back('{RES_CIPHER, h, l});
                    end
                    default: begin
                        cipher_block(1'b1, h, l);
                        awaited.push_back('{RES_PLAIN, h, l});
                    end
                endcase
            end
            if (m_valid && m_ready) begin
                got = '{m_result_kind, m_result_hi, m_result_lo};
                if (awaited.size() == 0) begin
                    $display("%0t unexpected result: actual %h", $time, got);
                    errors <= errors + 1;
                end else begin
                    want = awaited.pop_front();
                    if (got !== want) begin
                        $display("%0t result mismatch: expected kind %0d %h %h, actual kind %0d %h %h",
                                 $time, want.kind, want.hi, want.lo,
                                 got.kind, got.hi, got.lo);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end
endmodule

FILE: dv/single_sbox_blowfish_cipher_test.sv
// stimulus, clocking and verdict for the single s-box blowfish cipher
`timescale 1ns / 100ps
module single_sbox_blowfish_cipher_test;
    import sbbf_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_kind;
    logic [7:0]  s_key_byte;
    logic [31:0] s_block_hi;
    logic [31:0] s_block_lo;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_result_kind;
    logic [31:0] m_result_hi;
    logic [31:0] m_result_lo;
    int          errors;
    int          pending;

    // idle percentages for the sender and the receiver, changed per phase
    int          send_idle_pct;
    int          recv_stall_pct;
    logic        hold_req;     // asks the receiver for one long hold-off
    int          hold_left;
    longint      cycles;

    single_sbox_blowfish_cipher u_dut (
        .aclk, .aresetn,
        .s_valid, .s_ready, .s_kind, .s_key_byte, .s_block_hi, .s_block_lo,
        .m_valid, .m_ready, .m_result_kind, .m_result_hi, .m_result_lo
    );

    single_sbox_blowfish_cipher_checker u_checker (
        .aclk, .aresetn,
        .s_valid, .s_ready, .s_kind, .s_key_byte, .s_block_hi, .s_block_lo,
        .m_valid, .m_ready, .m_result_kind, .m_result_hi, .m_result_lo,
        .errors, .pending
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // receiver: random stalls, or one long hold-off so the block backs up
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (hold_req) begin
            hold_left <= 600;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // watchdog, far beyond the slowest legal run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 64'd4000000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // one transfer on the input channel; valid is left high for the next call
    task automatic push_item(input logic [1:0] kind, input logic [7:0] kb,
                             input logic [31:0] hi, input logic [31:0] lo);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_kind     <= kind;
        s_key_byte <= kb;
        s_block_hi <= hi;
        s_block_lo <= lo;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic push_block(input logic [31:0] hi, input logic [31:0] lo);
        push_item($urandom_range(0, 1) ? KIND_ENC : KIND_DEC, 8'($urandom()), hi, lo);
    endtask

    initial begin
        int blocks;
        int pick;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_kind         = KIND_KEY;
        s_key_byte     = '0;
        s_block_hi     = '0;
        s_block_lo     = '0;
        m_ready        = 1'b0;
        hold_req       = 1'b0;
        hold_left      = 0;
        cycles         = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty key schedule, extreme blocks, both directions
        push_item(KIND_SCHED, 8'h00, '0, '0);
        push_item(KIND_ENC, 8'h00, 32'h0, 32'h0);
        push_item(KIND_ENC, 8'hff, 32'hffffffff, 32'hffffffff);
        push_item(KIND_DEC, 8'h00, 32'h0, 32'h0);
        push_item(KIND_DEC, 8'h00, 32'hffffffff, 32'hffffffff);
        push_item(KIND_ENC, 8'h00, 32'h80000000, 32'h00000001);
        // one-byte key, then bytes appended later extend the same key
        push_item(KIND_KEY, 8'hff, '1, '1);
        push_item(KIND_SCHED, 8'h00, '0, '0);
        push_item(KIND_ENC, 8'h00, 32'h01234567, 32'h89abcdef);
        push_item(KIND_KEY, 8'h00, '0, '0);
        push_item(KIND_KEY, 8'h5a, '0, '0);
        push_item(KIND_SCHED, 8'h00, '0, '0);
        push_item(KIND_DEC, 8'h00, 32'hdeadbeef, 32'h00c0ffee);

        // random part in four idling phases; key grows until the store is full
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1) ? 51 : (ph == 3) ? 38 : 0;
            recv_stall_pct = (ph == 2) ? 51 : (ph == 3) ? 38 : 0;
            blocks = 0;
            while (blocks < 400) begin
                if (ph == 0 && blocks == 40) hold_req <= 1'b1;
                if (ph == 0 && blocks == 41) hold_req <= 1'b0;
                pick = $urandom_range(0, 999);
                if (pick < 4) begin
                    push_item(KIND_SCHED, 8'($urandom()), $urandom(), $urandom());
                end else if (pick < 80) begin
                    push_item(KIND_KEY, 8'($urandom()), $urandom(), $urandom());
                end else begin
                    push_block($urandom(), $urandom());
                    blocks++;
                end
            end
        end

        // overfill the key store so the saturation is seen, then use it
        for (int i = 0; i < 60; i++) push_item(KIND_KEY, 8'($urandom()), '0, '0);
        push_item(KIND_SCHED, 8'h00, '0, '0);
        for (int i = 0; i < 12; i++) push_block($urandom(), $urandom());
        s_valid <= 1'b0;

        while (pending != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (errors == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
